/* src/tssc_pkg.sv */
// ----------------------------------------------------------------------------
// tssc_pkg: shared types and constants of the two surface sensor calibrator
// Holds the transaction payload structs, the phase encoding and the lane
// command group passed from the controller to the channel lanes.
// ----------------------------------------------------------------------------
`default_nettype none

package tssc_pkg;

  localparam int unsigned LANES    = 8;
  localparam int unsigned CHANNELS = 8;   // active lanes, 1..LANES
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned WIN_W    = 22;
  localparam int unsigned REQ_W    = 2;
  localparam int unsigned CODE_W   = 2;

  localparam logic [SAMPLE_W-1:0] FULL_SCALE = 12'hFFF;
  localparam logic [WIN_W-1:0]    WIN_RESET  = 22'd10000;

  // request codes; the remaining code is a no-op
  localparam logic [REQ_W-1:0] REQ_SAMPLE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DARK   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_LIGHT  = 2'd2;

  // reported phase codes
  localparam logic [CODE_W-1:0] CODE_IDLE  = 2'd0;
  localparam logic [CODE_W-1:0] CODE_DARK  = 2'd1;
  localparam logic [CODE_W-1:0] CODE_WAIT  = 2'd2;
  localparam logic [CODE_W-1:0] CODE_LIGHT = 2'd3;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_DARK  = 4'b0010,
    PH_WAIT  = 4'b0100,
    PH_LIGHT = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [REQ_W-1:0]    req_type;
    logic [TIME_W-1:0]   time_ms;
    logic [SAMPLE_W-1:0] sample_0;
    logic [SAMPLE_W-1:0] sample_1;
    logic [SAMPLE_W-1:0] sample_2;
    logic [SAMPLE_W-1:0] sample_3;
    logic [SAMPLE_W-1:0] sample_4;
    logic [SAMPLE_W-1:0] sample_5;
    logic [SAMPLE_W-1:0] sample_6;
    logic [SAMPLE_W-1:0] sample_7;
  } in_item_t;

  typedef struct packed {
    logic [CODE_W-1:0]   phase_now;
    logic                calibrated;
    logic [SAMPLE_W-1:0] level_0;
    logic [SAMPLE_W-1:0] level_1;
    logic [SAMPLE_W-1:0] level_2;
    logic [SAMPLE_W-1:0] level_3;
    logic [SAMPLE_W-1:0] level_4;
    logic [SAMPLE_W-1:0] level_5;
    logic [SAMPLE_W-1:0] level_6;
    logic [SAMPLE_W-1:0] level_7;
  } out_item_t;

  // per-transaction command to every lane, at most one bit set
  typedef struct packed {
    logic start_dark;
    logic start_light;
    logic track_dark;
    logic track_light;
    logic compute;
  } lane_cmd_t;

  function automatic logic [CODE_W-1:0] phase_code(phase_e ph);
    logic [CODE_W-1:0] code;
    unique case (ph)
      PH_DARK:  code = CODE_DARK;
      PH_WAIT:  code = CODE_WAIT;
      PH_LIGHT: code = CODE_LIGHT;
      default:  code = CODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

/* src/two_surface_sensor_calibrator.sv */
// ----------------------------------------------------------------------------
// two_surface_sensor_calibrator: min/max calibration of a reflectance row
// Collects per-channel extremes over a dark and a light surface window
// and sets each threshold between the two surface midpoints.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i): one transaction is a
//   start-dark, start-light or sample-set request with a ms timestamp.
//   Output channel (out_valid_o / out_stall_i / out_data_o): exactly one
//   result transaction per input, carrying the phase, the calibrated flag
//   and the eight thresholds as they stand after that input.
//   Config channel (cfg_valid_i / cfg_ready_o / cfg_data_i): sets window_ms;
//   always ready, write only while the block is idle.
// Output: the result is registered and appears in the cycle after acceptance.
// Throughput: one transaction per cycle while the output is not stalled;
//   eight channel lanes update in parallel, and the controller's elapsed-time
//   subtract and compare is the combinational path that sets the rate.
// Reset: phase idle, all extremes, thresholds and start time zero,
//   calibrated low, window 10000 ms, output empty.
// Stall: while a result waits with out_stall_i high, in_stall_o is high;
//   the input is taken in the same cycle the held result drains.
// ----------------------------------------------------------------------------
`default_nettype none

module two_surface_sensor_calibrator (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  output logic                          in_stall_o,
  input  wire tssc_pkg::in_item_t       in_data_i,
  output logic                          out_valid_o,
  input  wire                           out_stall_i,
  output tssc_pkg::out_item_t           out_data_o,
  input  wire                           cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire [tssc_pkg::WIN_W-1:0]     cfg_data_i
);

  localparam int unsigned SW = tssc_pkg::SAMPLE_W;

  logic                         accept;
  logic [tssc_pkg::WIN_W-1:0]   window_q;
  tssc_pkg::lane_cmd_t          cmd;
  logic [tssc_pkg::CODE_W-1:0]  phase_code_d;
  logic                         done_d;
  logic [SW-1:0]                samples [tssc_pkg::LANES];
  logic [SW-1:0]                levels  [tssc_pkg::LANES];
  logic                         out_valid_q;
  tssc_pkg::out_item_t          out_q, out_d;

  // output slot is free or drains this cycle
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  // window register, config port never pushes back
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= tssc_pkg::WIN_RESET;
    end else if (cfg_valid_i) begin
      window_q <= cfg_data_i;
    end
  end

  tssc_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .req_i          (in_data_i.req_type),
    .time_i         (in_data_i.time_ms),
    .window_i       (window_q),
    .cmd_o          (cmd),
    .phase_code_d_o (phase_code_d),
    .done_d_o       (done_d)
  );

  assign samples[0] = in_data_i.sample_0;
  assign samples[1] = in_data_i.sample_1;
  assign samples[2] = in_data_i.sample_2;
  assign samples[3] = in_data_i.sample_3;
  assign samples[4] = in_data_i.sample_4;
  assign samples[5] = in_data_i.sample_5;
  assign samples[6] = in_data_i.sample_6;
  assign samples[7] = in_data_i.sample_7;

  // one lane per active channel; unused channels report zero
  for (genvar g = 0; g < tssc_pkg::LANES; g++) begin : g_lane
    if (g < tssc_pkg::CHANNELS) begin : g_on
      tssc_lane u_lane (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .cmd_i     (cmd),
        .sample_i  (samples[g]),
        .level_d_o (levels[g])
      );
    end else begin : g_off
      assign levels[g] = '0;
    end
  end

  // merge: controller status plus lane thresholds
  always_comb begin
    out_d            = '0;
    out_d.phase_now  = phase_code_d;
    out_d.calibrated = done_d;
    out_d.level_0    = levels[0];
    out_d.level_1    = levels[1];
    out_d.level_2    = levels[2];
    out_d.level_3    = levels[3];
    out_d.level_4    = levels[4];
    out_d.level_5    = levels[5];
    out_d.level_6    = levels[6];
    out_d.level_7    = levels[7];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // every accepted transaction yields a result next cycle
  a_accept_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted transaction produced no result");

endmodule

`default_nettype wire

/* src/tssc_lane.sv */
// ----------------------------------------------------------------------------
// tssc_lane: one sensor channel
// Tracks dark and light min/max of its channel and derives the threshold
// from the two surface midpoints. Presents the next threshold value.
// ----------------------------------------------------------------------------
`default_nettype none

module tssc_lane (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire tssc_pkg::lane_cmd_t          cmd_i,
  input  wire [tssc_pkg::SAMPLE_W-1:0]      sample_i,
  output logic [tssc_pkg::SAMPLE_W-1:0]     level_d_o
);

  localparam int unsigned SW = tssc_pkg::SAMPLE_W;

  logic [SW-1:0] dmin_q, dmin_d, dmax_q, dmax_d;
  logic [SW-1:0] lmin_q, lmin_d, lmax_q, lmax_d;
  logic [SW-1:0] level_q, level_d;
  logic [SW:0]   lsum, dsum, msum;

  // midpoint of midpoints, floor at each halving
  assign lsum = {1'b0, lmin_q} + {1'b0, lmax_q};
  assign dsum = {1'b0, dmin_q} + {1'b0, dmax_q};
  assign msum = {1'b0, lsum[SW:1]} + {1'b0, dsum[SW:1]};

  always_comb begin
    dmin_d  = dmin_q;
    dmax_d  = dmax_q;
    lmin_d  = lmin_q;
    lmax_d  = lmax_q;
    level_d = level_q;
    if (cmd_i.start_dark) begin
      dmin_d = tssc_pkg::FULL_SCALE;
      dmax_d = '0;
    end
    if (cmd_i.start_light) begin
      lmin_d = tssc_pkg::FULL_SCALE;
      lmax_d = '0;
    end
    if (cmd_i.track_dark) begin
      if (sample_i < dmin_q) dmin_d = sample_i;
      if (sample_i > dmax_q) dmax_d = sample_i;
    end
    if (cmd_i.track_light) begin
      if (sample_i < lmin_q) lmin_d = sample_i;
      if (sample_i > lmax_q) lmax_d = sample_i;
    end
    if (cmd_i.compute) begin
      level_d = msum[SW:1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dmin_q  <= '0;
      dmax_q  <= '0;
      lmin_q  <= '0;
      lmax_q  <= '0;
      level_q <= '0;
    end else begin
      dmin_q  <= dmin_d;
      dmax_q  <= dmax_d;
      lmin_q  <= lmin_d;
      lmax_q  <= lmax_d;
      level_q <= level_d;
    end
  end

  assign level_d_o = level_d;

endmodule

`default_nettype wire

/* src/tssc_ctrl.sv */
// ----------------------------------------------------------------------------
// tssc_ctrl: calibration phase controller
// Decodes requests, checks the collection window and issues the lane
// command for each accepted transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module tssc_ctrl (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              accept_i,
  input  wire [tssc_pkg::REQ_W-1:0]        req_i,
  input  wire [tssc_pkg::TIME_W-1:0]       time_i,
  input  wire [tssc_pkg::WIN_W-1:0]        window_i,
  output tssc_pkg::lane_cmd_t              cmd_o,
  output logic [tssc_pkg::CODE_W-1:0]      phase_code_d_o,
  output logic                             done_d_o
);

  localparam int unsigned TW = tssc_pkg::TIME_W;
  localparam int unsigned WW = tssc_pkg::WIN_W;

  tssc_pkg::phase_e    phase_q, phase_d;
  logic [TW-1:0]       start_q, start_d;
  logic                done_q, done_d;
  logic [TW-1:0]       elapsed;
  logic                in_window;
  tssc_pkg::lane_cmd_t cmd;

  // wrap-safe elapsed time
  assign elapsed   = time_i - start_q;
  assign in_window = elapsed < {{(TW-WW){1'b0}}, window_i};

  always_comb begin
    cmd     = '0;
    phase_d = phase_q;
    start_d = start_q;
    done_d  = done_q;
    if (accept_i) begin
      unique case (req_i)
        tssc_pkg::REQ_DARK: begin
          cmd.start_dark = 1'b1;
          phase_d        = tssc_pkg::PH_DARK;
          start_d        = time_i;
        end
        tssc_pkg::REQ_LIGHT: begin
          cmd.start_light = 1'b1;
          phase_d         = tssc_pkg::PH_LIGHT;
          start_d         = time_i;
        end
        tssc_pkg::REQ_SAMPLE: begin
          if (phase_q == tssc_pkg::PH_DARK) begin
            if (in_window) cmd.track_dark = 1'b1;
            else           phase_d = tssc_pkg::PH_WAIT;
          end else if (phase_q == tssc_pkg::PH_LIGHT) begin
            if (in_window) begin
              cmd.track_light = 1'b1;
            end else begin
              cmd.compute = 1'b1;
              done_d      = 1'b1;
              phase_d     = tssc_pkg::PH_IDLE;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= tssc_pkg::PH_IDLE;
      start_q <= '0;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      start_q <= start_d;
      done_q  <= done_d;
    end
  end

  assign cmd_o          = cmd;
  assign phase_code_d_o = tssc_pkg::phase_code(phase_d);
  assign done_d_o       = done_d;

  // once calibrated, stays calibrated
  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> done_q)
    else $error("calibrated flag dropped");

  // lanes only see work when a transaction is taken
  a_cmd_needs_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd != '0) |-> accept_i && $onehot(cmd))
    else $error("lane command without a single accepted transaction");

  a_compute_ends_light: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.compute |=> (phase_q == tssc_pkg::PH_IDLE) && done_q)
    else $error("threshold update did not close the light phase");

endmodule

`default_nettype wire

/* bench/two_surface_sensor_calibrator_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_surface_sensor_calibrator_test: self-checking bench of the calibrator
// Drives start-dark, start-light, sample-set and no-op transactions with
// random sender gaps and receiver stalls. A scoreboard keeps its own copy
// of the calibration state and checks every result field by field.
// ----------------------------------------------------------------------------

module two_surface_sensor_calibrator_test;
  import tssc_pkg::*;

  // unused request code; the block reports its state and changes nothing
  localparam logic [REQ_W-1:0] REQ_NOOP = 2'd3;

  localparam int unsigned PHASE_ITEMS     = 225;  // input transactions per window setting
  localparam int unsigned LONG_HOLD       = 150;  // cycles of receiver back-pressure
  localparam int unsigned LONG_HOLD_EVERY = 700;  // results between long holds
  localparam int unsigned DRAIN_LIMIT     = 4000;

  // --------------------------------------------------------------------------
  // Scoreboard: tracks phase, window start, per-surface extremes and levels,
  // and queues the status each accepted transaction should produce.
  // --------------------------------------------------------------------------
  class threshold_scoreboard;
    logic [WIN_W-1:0]    window;
    logic [CODE_W-1:0]   phase;
    logic [TIME_W-1:0]   window_start;
    logic [SAMPLE_W-1:0] dark_lo  [LANES];
    logic [SAMPLE_W-1:0] dark_hi  [LANES];
    logic [SAMPLE_W-1:0] light_lo [LANES];
    logic [SAMPLE_W-1:0] light_hi [LANES];
    logic [SAMPLE_W-1:0] level    [LANES];
    logic                calibrated;
    out_item_t           expected_status_q[$];
    int unsigned         mismatches;
    int unsigned         checked;
    int unsigned         calibrations;

    function new();
      window       = WIN_RESET;
      phase        = CODE_IDLE;
      window_start = '0;
      calibrated   = 1'b0;
      mismatches   = 0;
      checked      = 0;
      calibrations = 0;
      for (int i = 0; i < LANES; i++) begin
        dark_lo[i]  = '0;
        dark_hi[i]  = '0;
        light_lo[i] = '0;
        light_hi[i] = '0;
        level[i]    = '0;
      end
    endfunction

    function void set_window(logic [WIN_W-1:0] w);
      window = w;
    endfunction

    function int unsigned pending();
      return expected_status_q.size();
    endfunction

    // lanes past CHANNELS always read zero
    function logic [SAMPLE_W-1:0] lane_level(int i);
      return (i < CHANNELS) ? level[i] : '0;
    endfunction

    function void note_input(in_item_t it);
      logic [SAMPLE_W-1:0] s [LANES];
      logic [TIME_W-1:0]   elapsed;
      int unsigned         mid_l;
      int unsigned         mid_d;
      out_item_t           st;
      s[0] = it.sample_0;
      s[1] = it.sample_1;
      s[2] = it.sample_2;
      s[3] = it.sample_3;
      s[4] = it.sample_4;
      s[5] = it.sample_5;
      s[6] = it.sample_6;
      s[7] = it.sample_7;
      case (it.req_type)
        REQ_DARK: begin
          for (int i = 0; i < LANES; i++) begin
            dark_lo[i] = FULL_SCALE;
            dark_hi[i] = '0;
          end
          window_start = it.time_ms;
          phase        = CODE_DARK;
        end
        REQ_LIGHT: begin
          for (int i = 0; i < LANES; i++) begin
            light_lo[i] = FULL_SCALE;
            light_hi[i] = '0;
          end
          window_start = it.time_ms;
          phase        = CODE_LIGHT;
        end
        REQ_SAMPLE: begin
          if (phase == CODE_DARK || phase == CODE_LIGHT) begin
            elapsed = it.time_ms - window_start;   // wraps mod 2^32
            if (elapsed < window) begin
              for (int i = 0; i < LANES; i++) begin
                if (i < CHANNELS) begin
                  if (phase == CODE_DARK) begin
                    if (s[i] < dark_lo[i]) dark_lo[i] = s[i];
                    if (s[i] > dark_hi[i]) dark_hi[i] = s[i];
                  end else begin
                    if (s[i] < light_lo[i]) light_lo[i] = s[i];
                    if (s[i] > light_hi[i]) light_hi[i] = s[i];
                  end
                end
              end
            end else if (phase == CODE_DARK) begin
              phase = CODE_WAIT;
            end else begin
              // threshold halfway between the two surface midpoints
              for (int i = 0; i < LANES; i++) begin
                if (i < CHANNELS) begin
                  mid_l    = (32'(light_lo[i]) + 32'(light_hi[i])) >> 1;
                  mid_d    = (32'(dark_lo[i]) + 32'(dark_hi[i])) >> 1;
                  level[i] = SAMPLE_W'((mid_l + mid_d) >> 1);
                end
              end
              calibrated = 1'b1;
              phase      = CODE_IDLE;
              calibrations++;
            end
          end
        end
        default: ;
      endcase
      st.phase_now  = phase;
      st.calibrated = calibrated;
      st.level_0    = lane_level(0);
      st.level_1    = lane_level(1);
      st.level_2    = lane_level(2);
      st.level_3    = lane_level(3);
      st.level_4    = lane_level(4);
      st.level_5    = lane_level(5);
      st.level_6    = lane_level(6);
      st.level_7    = lane_level(7);
      expected_status_q.push_back(st);
    endfunction

    function void cmp_field(string field, logic [31:0] exp_v, logic [31:0] got_v);
      if (got_v !== exp_v) begin
        mismatches++;
        if (mismatches <= 10)
          $display("MISMATCH result %0d %s: expected %0d got %0d",
                   checked, field, exp_v, got_v);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_st;
      if (expected_status_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("MISMATCH unexpected result: phase %0d calibrated %0d",
                   got.phase_now, got.calibrated);
        return;
      end
      exp_st = expected_status_q.pop_front();
      checked++;
      cmp_field("phase_now", exp_st.phase_now, got.phase_now);
      cmp_field("calibrated", exp_st.calibrated, got.calibrated);
      cmp_field("level_0", exp_st.level_0, got.level_0);
      cmp_field("level_1", exp_st.level_1, got.level_1);
      cmp_field("level_2", exp_st.level_2, got.level_2);
      cmp_field("level_3", exp_st.level_3, got.level_3);
      cmp_field("level_4", exp_st.level_4, got.level_4);
      cmp_field("level_5", exp_st.level_5, got.level_5);
      cmp_field("level_6", exp_st.level_6, got.level_6);
      cmp_field("level_7", exp_st.level_7, got.level_7);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the block's ports; every input starts at a known value
  // --------------------------------------------------------------------------
  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  in_item_t         in_data   = '0;
  logic             in_stall;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_item_t        out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [WIN_W-1:0] cfg_data  = '0;

  always #5 clk = ~clk;

  two_surface_sensor_calibrator DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  threshold_scoreboard sb = new();

  int unsigned items_counted = 0;   // starts and samples of the sequences, plus every directed transaction
  int unsigned items_sent    = 0;   // every accepted input transaction
  int unsigned results_seen  = 0;
  int unsigned windows_used  = 0;
  int unsigned tx_calm       = 0;   // remaining back-to-back stretch, sender side
  int unsigned rx_calm       = 0;   // same for the receiver

  // Wait length per transaction is drawn at random, with occasional runs of
  // zero so that full-rate stretches occur on both sides.
  function automatic int unsigned draw_wait(inout int unsigned calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      calm_left = $urandom_range(8, 48);
      return 0;
    end
    return $urandom_range(0, 14);
  endfunction

  // Extremes show up often so min/max tracking sees its boundaries.
  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return FULL_SCALE;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic in_item_t make_item(logic [REQ_W-1:0] req, logic [TIME_W-1:0] t);
    in_item_t it;
    it.req_type = req;
    it.time_ms  = t;
    it.sample_0 = rand_sample();
    it.sample_1 = rand_sample();
    it.sample_2 = rand_sample();
    it.sample_3 = rand_sample();
    it.sample_4 = rand_sample();
    it.sample_5 = rand_sample();
    it.sample_6 = rand_sample();
    it.sample_7 = rand_sample();
    return it;
  endfunction

  function automatic in_item_t flat_item(logic [REQ_W-1:0] req, logic [TIME_W-1:0] t,
                                         logic [SAMPLE_W-1:0] s);
    in_item_t it;
    it          = make_item(req, t);
    it.sample_0 = s;
    it.sample_1 = s;
    it.sample_2 = s;
    it.sample_3 = s;
    it.sample_4 = s;
    it.sample_5 = s;
    it.sample_6 = s;
    it.sample_7 = s;
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Input side. Entered right after a rising edge; valid stays high across
  // back-to-back transactions and is lowered only when a gap is drawn or on a drain.
  // Acceptance is judged from the values that stood at the edge.
  // --------------------------------------------------------------------------
  task automatic send_item(input in_item_t it, input bit counted);
    int unsigned gap;
    gap = draw_wait(tx_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(it);
    items_sent++;
    if (counted) items_counted++;
  endtask

  // Let every expected result come back and wait out the output register,
  // so the block is idle before a window change.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_window(input logic [WIN_W-1:0] w);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_window(w);
    windows_used++;
  endtask

  // One surface window: start command, a few in-window sample sets with
  // stray no-ops, then optionally a sample at or past the window to close it.
  task automatic run_window(input logic [REQ_W-1:0] start_req,
                            input logic [WIN_W-1:0] w, input bit finish);
    logic [TIME_W-1:0] t0;
    logic [TIME_W-1:0] e;
    int unsigned       n;
    t0 = $urandom;
    n  = $urandom_range(0, 10);
    send_item(make_item(start_req, t0), 1'b1);
    repeat (n) begin
      if ($urandom_range(0, 9) == 0)
        send_item(make_item(REQ_NOOP, $urandom), 1'b0);
      if (w != 0) begin
        case ($urandom_range(0, 3))
          0:       e = '0;
          1:       e = w - 1;
          default: e = $urandom_range(0, w - 1);
        endcase
        send_item(make_item(REQ_SAMPLE, t0 + e), 1'b1);
      end
    end
    if (finish) begin
      case ($urandom_range(0, 3))
        0:       e = w;
        1:       e = w + $urandom_range(0, 1000);
        2:       e = '1;                                  // largest elapsed time
        default: e = w + $urandom_range(0, 32'h7FFF_FFFF);
      endcase
      send_item(make_item(REQ_SAMPLE, t0 + e), 1'b1);
    end
  endtask

  // --------------------------------------------------------------------------
  // Output side: check each accepted result, then draw a stall for the next.
  // Every LONG_HOLD_EVERY results the receiver starts a long hold, so the
  // block backs up and stalls its input.
  // --------------------------------------------------------------------------
  initial begin : result_monitor
    int unsigned hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        sb.check_result(out_data);
        results_seen++;
        hold = draw_wait(rx_calm);
        if (results_seen % LONG_HOLD_EVERY == LONG_HOLD_EVERY / 2) hold = LONG_HOLD;
      end else if (hold > 0) begin
        hold--;
      end
      out_stall <= (hold > 0);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : main_flow
    logic [WIN_W-1:0]  windows [8];
    logic [TIME_W-1:0] t0;
    int unsigned       budget;
    int unsigned       waited;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, reset window of 10000 ms first.
    send_item(flat_item(REQ_NOOP, '1, FULL_SCALE), 1'b1);        // no-op in idle
    send_item(flat_item(REQ_SAMPLE, '0, '0), 1'b1);              // sample while idle
    t0 = 32'hFFFF_FFF0;
    send_item(flat_item(REQ_LIGHT, t0, '0), 1'b1);               // light before any dark
    send_item(flat_item(REQ_SAMPLE, 32'hFFFF_FFFF, FULL_SCALE), 1'b1);
    send_item(flat_item(REQ_SAMPLE, 32'd5, '0), 1'b1);           // timestamp wrapped
    send_item(make_item(REQ_SAMPLE, t0 + 32'd9999), 1'b1);       // last ms in window
    send_item(make_item(REQ_SAMPLE, t0 + 32'd10000), 1'b1);      // closes, dark still zero
    send_item(flat_item(REQ_NOOP, '0, '0), 1'b1);
    send_item(make_item(REQ_DARK, 32'd100), 1'b1);
    send_item(make_item(REQ_SAMPLE, 32'd100), 1'b1);             // zero elapsed
    send_item(make_item(REQ_LIGHT, 32'd200), 1'b1);              // restart mid dark
    send_item(make_item(REQ_DARK, 32'd300), 1'b1);               // restart mid light
    send_item(flat_item(REQ_SAMPLE, 32'd301, 12'hA5A), 1'b1);
    send_item(flat_item(REQ_NOOP, 32'd302, 12'h5A5), 1'b1);      // no-op mid collection
    send_item(make_item(REQ_SAMPLE, 32'd10300), 1'b1);           // dark ends, waiting
    send_item(make_item(REQ_SAMPLE, 32'd10301), 1'b1);           // ignored while waiting
    send_item(make_item(REQ_NOOP, '0), 1'b1);
    t0 = 32'h8000_0000;
    send_item(make_item(REQ_LIGHT, t0), 1'b1);
    send_item(make_item(REQ_SAMPLE, t0 + 32'd5), 1'b1);
    send_item(make_item(REQ_SAMPLE, t0 - 32'd1), 1'b1);          // elapsed at its maximum
    write_window('0);                                             // zero window
    send_item(make_item(REQ_DARK, 32'd7), 1'b1);
    send_item(make_item(REQ_SAMPLE, 32'd7), 1'b1);               // first sample closes it
    send_item(make_item(REQ_LIGHT, 32'd9), 1'b1);
    send_item(make_item(REQ_SAMPLE, 32'd9), 1'b1);

    // Random part: one stretch per window setting, mostly full dark/light
    // sequences with random content, the rest stray transactions.
    windows[0] = 22'd1;
    windows[1] = 22'd3600000;
    windows[2] = 22'd17;
    windows[3] = WIN_W'($urandom_range(1, 3600000));
    windows[4] = '0;
    windows[5] = 22'd1000;
    windows[6] = WIN_W'($urandom_range(1, 64));
    windows[7] = WIN_RESET;
    foreach (windows[k]) begin
      write_window(windows[k]);
      budget = items_sent + PHASE_ITEMS;
      while (items_sent < budget) begin
        if ($urandom_range(0, 9) < 8) begin
          run_window(REQ_DARK, windows[k], $urandom_range(0, 4) != 0);
          repeat ($urandom_range(0, 2))
            send_item(make_item(REQ_W'($urandom_range(0, 1) ? REQ_SAMPLE : REQ_NOOP),
                                $urandom), 1'b0);
          run_window(REQ_LIGHT, windows[k], $urandom_range(0, 5) != 0);
        end else begin
          send_item(make_item(REQ_W'($urandom_range(0, 3)), $urandom), 1'b0);
        end
      end
    end

    // Wind down: wait for outstanding results, bounded.
    in_valid <= 1'b0;
    waited = 0;
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (5) @(posedge clk);

    $display("Run covered %0d input transactions (%0d within calibration sequences)",
             items_sent, items_counted);
    $display("and %0d checked results, with %0d completed calibrations over %0d windows.",
             sb.checked, sb.calibrations, windows_used);
    if (sb.pending() != 0)
      $display("%0d expected results never arrived", sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog, well beyond the slowest legal run.
  initial begin : watchdog
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

/* sim.f */
src/tssc_pkg.sv
src/tssc_lane.sv
src/tssc_ctrl.sv
src/two_surface_sensor_calibrator.sv
bench/two_surface_sensor_calibrator_test.sv
